// File: src/xenc_pkg.sv
// ----------------------------------------------------------------------------
// xenc_pkg
// Shared types and constants of the x86-64 instruction encoder.
// ----------------------------------------------------------------------------
package xenc_pkg;

  localparam int unsigned NumSlots = 12;

  // Fixed slot layout of an encoded instruction before compaction.
  localparam int unsigned SlotRex   = 0;
  localparam int unsigned SlotOp    = 1;
  localparam int unsigned SlotModrm = 2;
  localparam int unsigned SlotSib   = 3;
  localparam int unsigned SlotDisp  = 4;
  localparam int unsigned SlotImm   = 8;

  localparam logic [7:0] RexW      = 8'h48;
  localparam logic [7:0] OpAddRRm  = 8'h03;
  localparam logic [7:0] OpAddRmR  = 8'h01;
  localparam logic [7:0] OpAndRRm  = 8'h23;
  localparam logic [7:0] OpAndRmR  = 8'h21;
  localparam logic [7:0] OpGrp1Imm = 8'h81;
  localparam logic [7:0] OpGrp3    = 8'hF7;
  localparam logic [7:0] OpJmpRel  = 8'hE9;
  localparam logic [7:0] OpEscape  = 8'h0F;
  localparam logic [7:0] OpJccBase = 8'h80;
  localparam logic [7:0] SibAbs    = 8'h25;

  localparam logic [2:0] ExtAdd = 3'd0;
  localparam logic [2:0] ExtAnd = 3'd4;
  localparam logic [2:0] ExtMul = 3'd4;
  localparam logic [2:0] RmSib  = 3'd4;
  localparam logic [2:0] RmRip  = 3'd5;

  localparam logic [1:0] ModInd   = 2'd0;
  localparam logic [1:0] ModDisp8 = 2'd1;
  localparam logic [1:0] ModDisp32 = 2'd2;
  localparam logic [1:0] ModReg   = 2'd3;

  typedef enum logic [3:0] {
    CMD_ADD_R_RM = 4'd0,
    CMD_ADD_RM_R = 4'd1,
    CMD_ADD_IMM  = 4'd2,
    CMD_AND_R_RM = 4'd3,
    CMD_AND_RM_R = 4'd4,
    CMD_AND_IMM  = 4'd5,
    CMD_MUL      = 4'd6,
    CMD_JMP      = 4'd7,
    CMD_JCC      = 4'd8
  } cmd_e;

  typedef enum logic [3:0] {
    AM_REG      = 4'd0,
    AM_BASE     = 4'd1,
    AM_BASE_D8  = 4'd2,
    AM_BASE_D32 = 4'd3,
    AM_SIB      = 4'd4,
    AM_SIB_D8   = 4'd5,
    AM_SIB_D32  = 4'd6,
    AM_RIP      = 4'd7,
    AM_ABS      = 4'd8
  } addr_mode_e;

  // One classified instruction: bytes in fixed slots and the slots present.
  typedef struct packed {
    logic [NumSlots-1:0][7:0] bytes;
    logic [NumSlots-1:0]      mask;
    logic                     err;
  } desc_t;

endpackage

// File: src/xenc_if.sv
// ----------------------------------------------------------------------------
// xenc_if
// Valid/ready channels for instruction requests and encoded bytes.
// ----------------------------------------------------------------------------
interface xenc_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [3:0]  addr_mode;
  logic [3:0]  reg_num;
  logic [3:0]  base_num;
  logic [3:0]  index_num;
  logic [1:0]  scale_log;
  logic [31:0] displacement;
  logic [31:0] immediate;
  logic [3:0]  cond_code;

  modport source (
    output valid, cmd, addr_mode, reg_num, base_num, index_num, scale_log,
           displacement, immediate, cond_code,
    input  ready
  );
  modport sink (
    input  valid, cmd, addr_mode, reg_num, base_num, index_num, scale_log,
           displacement, immediate, cond_code,
    output ready
  );
endinterface

interface xenc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;
  logic       bad_operand;

  modport source (output valid, code_byte, last_byte, bad_operand, input ready);
  modport sink   (input valid, code_byte, last_byte, bad_operand, output ready);
endinterface

// File: src/xenc_front.sv
// ----------------------------------------------------------------------------
// xenc_front
// Accepts requests and classifies each into a slot descriptor for the queue.
// ----------------------------------------------------------------------------
module xenc_front import xenc_pkg::*; (
  xenc_req_if.sink req,
  input  logic     q_full_i,
  output logic     push_o,
  output desc_t    desc_o
);

  logic [2:0] regf;
  logic       rexr;
  logic       rexx;
  logic       rexb;
  logic [1:0] modf;
  logic [2:0] rmf;
  logic [7:0] sibf;
  logic [7:0] opc;
  logic       has_imm;
  logic       has_sib;
  logic       d8;
  logic       d32;
  logic       bad;
  logic [2:0] blo;

  assign req.ready = !q_full_i;
  assign push_o    = req.valid && !q_full_i;
  assign blo       = req.base_num[2:0];

  always_comb begin
    regf    = req.reg_num[2:0];
    rexr    = req.reg_num[3];
    rexx    = 1'b0;
    rexb    = 1'b0;
    modf    = ModInd;
    rmf     = blo;
    sibf    = 8'h00;
    opc     = OpGrp3;
    has_imm = 1'b0;
    has_sib = 1'b0;
    d8      = 1'b0;
    d32     = 1'b0;
    bad     = 1'b0;
    desc_o  = '0;

    case (cmd_e'(req.cmd))
      CMD_ADD_R_RM: opc = OpAddRRm;
      CMD_ADD_RM_R: opc = OpAddRmR;
      CMD_AND_R_RM: opc = OpAndRRm;
      CMD_AND_RM_R: opc = OpAndRmR;
      CMD_ADD_IMM: begin
        opc = OpGrp1Imm; regf = ExtAdd; rexr = 1'b0; has_imm = 1'b1;
      end
      CMD_AND_IMM: begin
        opc = OpGrp1Imm; regf = ExtAnd; rexr = 1'b0; has_imm = 1'b1;
      end
      CMD_MUL: begin
        opc = OpGrp3; regf = ExtMul; rexr = 1'b0;
      end
      CMD_JMP, CMD_JCC: ;
      default: bad = 1'b1;
    endcase

    case (addr_mode_e'(req.addr_mode))
      AM_REG: begin
        modf = ModReg; rexb = req.base_num[3];
      end
      AM_BASE: begin
        rexb = req.base_num[3];
        if (blo == 3'd4 || blo == 3'd5) bad = 1'b1;
      end
      AM_BASE_D8: begin
        modf = ModDisp8; rexb = req.base_num[3]; d8 = 1'b1;
        if (blo == RmSib) bad = 1'b1;
      end
      AM_BASE_D32: begin
        modf = ModDisp32; rexb = req.base_num[3]; d32 = 1'b1;
        if (blo == RmSib) bad = 1'b1;
      end
      AM_SIB, AM_SIB_D8, AM_SIB_D32: begin
        rmf     = RmSib;
        has_sib = 1'b1;
        sibf    = {req.scale_log, req.index_num[2:0], blo};
        rexx    = req.index_num[3];
        rexb    = req.base_num[3];
        if (addr_mode_e'(req.addr_mode) == AM_SIB_D8) begin
          modf = ModDisp8; d8 = 1'b1;
        end else if (addr_mode_e'(req.addr_mode) == AM_SIB_D32) begin
          modf = ModDisp32; d32 = 1'b1;
        end else if (blo == RmRip) begin
          // Base 5 with no displacement would mean disp32 without a base.
          bad = 1'b1;
        end
      end
      AM_RIP: begin
        rmf = RmRip; d32 = 1'b1;
      end
      AM_ABS: begin
        rmf = RmSib; has_sib = 1'b1; sibf = SibAbs; d32 = 1'b1;
      end
      default: bad = 1'b1;
    endcase

    for (int k = 0; k < 4; k++) begin
      desc_o.bytes[SlotDisp + k] = req.displacement[8*k +: 8];
      desc_o.bytes[SlotImm + k]  = req.immediate[8*k +: 8];
    end
    desc_o.bytes[SlotRex] = RexW;

    if (cmd_e'(req.cmd) == CMD_JMP) begin
      // Jumps ignore every addressing field but the displacement, which is rel32.
      desc_o.bytes[SlotOp] = OpJmpRel;
      desc_o.mask          = 12'h0F3;
    end else if (cmd_e'(req.cmd) == CMD_JCC) begin
      desc_o.bytes[SlotOp]    = OpEscape;
      desc_o.bytes[SlotModrm] = OpJccBase + {4'h0, req.cond_code};
      desc_o.mask             = 12'h0F7;
    end else if (bad) begin
      desc_o     = '0;
      desc_o.err = 1'b1;
      desc_o.mask[SlotRex] = 1'b1;
    end else begin
      desc_o.bytes[SlotRex]   = RexW | {5'b0, rexr, rexx, rexb};
      desc_o.bytes[SlotOp]    = opc;
      desc_o.bytes[SlotModrm] = {modf, regf, rmf};
      desc_o.bytes[SlotSib]   = sibf;
      desc_o.mask[2:0]        = 3'b111;
      desc_o.mask[SlotSib]    = has_sib;
      desc_o.mask[SlotDisp]   = d8 || d32;
      desc_o.mask[SlotDisp+1] = d32;
      desc_o.mask[SlotDisp+2] = d32;
      desc_o.mask[SlotDisp+3] = d32;
      desc_o.mask[SlotImm +: 4] = {4{has_imm}};
    end
  end

endmodule

// File: src/xenc_fifo.sv
// ----------------------------------------------------------------------------
// xenc_fifo
// Two-entry queue of instruction descriptors between front and back.
// ----------------------------------------------------------------------------
module xenc_fifo import xenc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t wdata_i,
  input  logic  pop_i,
  output desc_t rdata_o,
  output logic  full_o,
  output logic  empty_o
);

  desc_t      mem_q [2];
  logic       wr_ptr_q;
  logic       wr_ptr_d;
  logic       rd_ptr_q;
  logic       rd_ptr_d;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

// File: src/xenc_back.sv
// ----------------------------------------------------------------------------
// xenc_back
// Walks the present slots of one descriptor and emits one byte per item.
// ----------------------------------------------------------------------------
module xenc_back import xenc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  desc_t desc_i,
  input  logic  empty_i,
  output logic  pop_o,
  xenc_rsp_if.source rsp
);

  logic [NumSlots-1:0][7:0] bytes_q;
  logic [NumSlots-1:0][7:0] bytes_d;
  logic [NumSlots-1:0]      mask_q;
  logic [NumSlots-1:0]      mask_d;
  logic                     err_q;
  logic                     err_d;
  logic [NumSlots-1:0]      sel;
  logic [NumSlots-1:0]      rem;
  logic [7:0]               pick;
  logic                     emit;
  logic                     ov_q;
  logic                     ov_d;
  logic [7:0]               byte_q;
  logic                     last_q;
  logic                     bad_q;

  always_comb begin
    // Lowest remaining slot goes out next.
    sel  = mask_q & (~mask_q + {{(NumSlots-1){1'b0}}, 1'b1});
    rem  = mask_q & ~sel;
    pick = 8'h00;
    for (int i = 0; i < NumSlots; i++) begin
      if (sel[i]) pick = pick | bytes_q[i];
    end
    emit  = (mask_q != '0) && (!ov_q || rsp.ready);
    pop_o = !empty_i && ((mask_q == '0) || (emit && rem == '0));

    bytes_d = bytes_q;
    err_d   = err_q;
    mask_d  = emit ? rem : mask_q;
    if (pop_o) begin
      bytes_d = desc_i.bytes;
      mask_d  = desc_i.mask;
      err_d   = desc_i.err;
    end
    ov_d = emit ? 1'b1 : (rsp.ready ? 1'b0 : ov_q);
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    err_q   <= err_d;
    if (emit) begin
      byte_q <= pick;
      last_q <= (rem == '0);
      bad_q  <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      mask_q <= mask_d;
      ov_q   <= ov_d;
    end
  end

  assign rsp.valid       = ov_q;
  assign rsp.code_byte   = byte_q;
  assign rsp.last_byte   = last_q;
  assign rsp.bad_operand = bad_q;

  a_sel_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> $onehot(sel))
    else $error("byte selection not one-hot");

  a_err_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && mask_q != '0) |-> (mask_q == 12'h001))
    else $error("error descriptor carries more than one slot");

  a_bad_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && bad_q) |-> (last_q && byte_q == 8'h00))
    else $error("error item is not a lone zero byte");

endmodule

// File: src/x86_64_instruction_encoder.sv
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder
// Encodes ADD, AND, MUL, JMP and Jcc requests into x86-64 machine code bytes.
// ----------------------------------------------------------------------------
//   Channel   Dir   Item                       Payload
//   req_i     in    one instruction request    cmd, addr_mode, reg_num, ...
//   rsp_o     out   one machine-code byte      code_byte, last_byte, bad_operand
//
// An instruction leaves as 1 to 12 items, one per cycle from the byte walker
// while rsp_o is ready, one item for each of its bytes.
// A request is taken whenever the two-entry descriptor queue has room, while
// the walker still emits earlier bytes; it then goes through the queue and the
// walker to the output register. Reset clears queue, walker and output valid.
// Back-pressure on rsp_o holds the output register and fills the queue.
// ----------------------------------------------------------------------------
module x86_64_instruction_encoder import xenc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  xenc_req_if.sink   req_i,
  xenc_rsp_if.source rsp_o
);

  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  desc_t wdesc;
  desc_t rdesc;

  xenc_front u_front (
    .req      (req_i),
    .q_full_i (full),
    .push_o   (push),
    .desc_o   (wdesc)
  );

  xenc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdesc),
    .pop_i   (pop),
    .rdata_o (rdesc),
    .full_o  (full),
    .empty_o (empty)
  );

  xenc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .desc_i  (rdesc),
    .empty_i (empty),
    .pop_o   (pop),
    .rsp     (rsp_o)
  );

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the x86-64 instruction encoder. A table of directed
// requests, then random ones, go in over a valid/ready channel with random
// gaps. Each byte that leaves is checked against the table or a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import xenc_pkg::*;

  localparam int unsigned ResetCycles    = 10;
  localparam int unsigned NumDirected    = 25;
  localparam int unsigned RandomItems    = 355;
  localparam int unsigned SteadyFirst    = 150;
  localparam int unsigned SteadyLast     = 230;
  localparam int unsigned HoldAfterBytes = 60;
  localparam int unsigned LongHold       = 300;
  localparam int unsigned DrainCycles    = 40;
  localparam int unsigned CycleLimit     = 1000000;

  // Command and mode codes outside the defined sets.
  localparam logic [3:0] CmdBadLo = 4'd9;
  localparam logic [3:0] CmdBadHi = 4'd15;
  localparam logic [3:0] AmBadLo  = 4'd9;
  localparam logic [3:0] AmBadHi  = 4'd15;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [3:0]  addr_mode;
    logic [3:0]  reg_num;
    logic [3:0]  base_num;
    logic [3:0]  index_num;
    logic [1:0]  scale_log;
    logic [31:0] displacement;
    logic [31:0] immediate;
    logic [3:0]  cond_code;
  } request_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       bad;
  } code_item_t;

  // exp_len of zero leaves the row to the encoder model; otherwise the bytes
  // are given here, first byte in the low bits.
  typedef struct packed {
    request_t    req;
    logic [3:0]  exp_len;
    logic [95:0] exp_bytes;
    logic        exp_bad;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  xenc_req_if req_if ();
  xenc_rsp_if rsp_if ();

  x86_64_instruction_encoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  code_item_t  expected_code [$];
  int unsigned fail_count     = 0;
  int unsigned bytes_checked  = 0;
  int unsigned instrs_encoded = 0;
  int unsigned instrs_sent    = 0;
  int unsigned jumps_sent     = 0;
  int unsigned rejects_sent   = 0;
  bit          steady_run     = 1'b0;

  stim_row_t directed_rows [NumDirected] = '{
    '{'{CMD_ADD_R_RM, AM_REG, 0, 0, 0, 0, 32'h0, 32'h0, 0}, 4'd3, 96'hC00348, 1'b0},
    '{'{CMD_ADD_RM_R, AM_REG, 15, 15, 15, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 15},
      4'd0, 96'h0, 1'b0},
    '{'{CMD_ADD_IMM, AM_SIB_D32, 15, 15, 15, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 15},
      4'd0, 96'h0, 1'b0},
    '{'{CMD_AND_R_RM, AM_BASE, 9, 3, 0, 0, 32'h0, 32'h0, 0}, 4'd0, 96'h0, 1'b0},
    '{'{CMD_AND_RM_R, AM_BASE_D8, 2, 13, 0, 0, 32'h80, 32'h0, 0}, 4'd0, 96'h0, 1'b0},
    '{'{CMD_AND_IMM, AM_BASE_D32, 0, 0, 0, 0, 32'h0, 32'h0, 0}, 4'd0, 96'h0, 1'b0},
    '{'{CMD_MUL, AM_SIB, 7, 0, 4, 0, 32'h0, 32'h0, 0}, 4'd0, 96'h0, 1'b0},
    '{'{CMD_ADD_R_RM, AM_SIB_D8, 8, 5, 12, 2, 32'h7F, 32'h0, 0}, 4'd0, 96'h0, 1'b0},
    '{'{CMD_MUL, AM_RIP, 15, 15, 15, 1, 32'hDEADBEEF, 32'h0, 0}, 4'd0, 96'h0, 1'b0},
    '{'{CMD_ADD_IMM, AM_ABS, 15, 15, 15, 3, 32'h00000001, 32'h7FFFFFFF, 0},
      4'd0, 96'h0, 1'b0},
    '{'{CMD_JMP, AmBadHi, 15, 15, 15, 3, 32'h12345678, 32'hFFFFFFFF, 15},
      4'd6, 96'h12345678E948, 1'b0},
    '{'{CMD_JCC, AM_REG, 0, 0, 0, 0, 32'h0, 32'h0, 0}, 4'd7, 96'h800F48, 1'b0},
    '{'{CMD_JCC, AM_SIB, 15, 4, 15, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 15},
      4'd7, 96'hFFFFFFFF8F0F48, 1'b0},
    '{'{CmdBadHi, AM_REG, 0, 0, 0, 0, 32'h0, 32'h0, 0}, 4'd1, 96'h0, 1'b1},
    '{'{CmdBadLo, AM_BASE_D8, 3, 3, 3, 1, 32'h55, 32'hAA, 3}, 4'd1, 96'h0, 1'b1},
    '{'{CMD_ADD_R_RM, AmBadLo, 1, 1, 1, 1, 32'h0, 32'h0, 0}, 4'd1, 96'h0, 1'b1},
    '{'{CMD_AND_IMM, AmBadHi, 1, 1, 1, 1, 32'h0, 32'h0, 0}, 4'd1, 96'h0, 1'b1},
    '{'{CMD_ADD_RM_R, AM_BASE, 2, 4, 0, 0, 32'h0, 32'h0, 0}, 4'd1, 96'h0, 1'b1},
    '{'{CMD_MUL, AM_BASE, 2, 13, 0, 0, 32'h0, 32'h0, 0}, 4'd1, 96'h0, 1'b1},
    '{'{CMD_AND_R_RM, AM_BASE_D8, 2, 12, 0, 0, 32'h0, 32'h0, 0}, 4'd1, 96'h0, 1'b1},
    '{'{CMD_ADD_IMM, AM_BASE_D32, 2, 4, 0, 0, 32'h0, 32'h0, 0}, 4'd1, 96'h0, 1'b1},
    '{'{CMD_AND_RM_R, AM_SIB, 2, 5, 1, 0, 32'h0, 32'h0, 0}, 4'd1, 96'h0, 1'b1},
    '{'{CMD_ADD_R_RM, AM_SIB, 2, 13, 1, 0, 32'h0, 32'h0, 0}, 4'd1, 96'h0, 1'b1},
    '{'{CMD_AND_RM_R, AM_BASE_D32, 11, 5, 0, 0, 32'h80000000, 32'h0, 0},
      4'd0, 96'h0, 1'b0},
    '{'{CMD_MUL, AM_REG, 0, 8, 0, 0, 32'h0, 32'h0, 0}, 4'd0, 96'h0, 1'b0}
  };

  // Works out the byte sequence of one request and queues it.
  function automatic void encode_instruction(input request_t r);
    logic [7:0] enc [$];
    logic [7:0] opcode;
    logic [7:0] sib;
    logic [3:0] regf;
    logic [2:0] blo;
    logic [2:0] rm;
    logic [1:0] mod_f;
    logic       rex_x;
    logic       rex_b;
    int unsigned disp_len;
    bit          has_sib;
    bit          has_imm;
    bit          bad;

    opcode   = 8'h00;
    sib      = 8'h00;
    regf     = 4'h0;
    blo      = r.base_num[2:0];
    rm       = 3'd0;
    mod_f    = ModInd;
    rex_x    = 1'b0;
    rex_b    = 1'b0;
    disp_len = 0;
    has_sib  = 1'b0;
    has_imm  = 1'b0;
    bad      = 1'b0;

    if (r.cmd == CMD_JMP || r.cmd == CMD_JCC) begin
      enc.push_back(RexW);
      if (r.cmd == CMD_JMP) begin
        enc.push_back(OpJmpRel);
      end else begin
        enc.push_back(OpEscape);
        enc.push_back(OpJccBase + {4'h0, r.cond_code});
      end
      for (int i = 0; i < 4; i++) enc.push_back(r.displacement[8*i +: 8]);
    end else begin
      case (r.cmd)
        CMD_ADD_R_RM: begin opcode = OpAddRRm;  regf = r.reg_num; end
        CMD_ADD_RM_R: begin opcode = OpAddRmR;  regf = r.reg_num; end
        CMD_ADD_IMM:  begin opcode = OpGrp1Imm; regf = {1'b0, ExtAdd}; has_imm = 1'b1; end
        CMD_AND_R_RM: begin opcode = OpAndRRm;  regf = r.reg_num; end
        CMD_AND_RM_R: begin opcode = OpAndRmR;  regf = r.reg_num; end
        CMD_AND_IMM:  begin opcode = OpGrp1Imm; regf = {1'b0, ExtAnd}; has_imm = 1'b1; end
        CMD_MUL:      begin opcode = OpGrp3;    regf = {1'b0, ExtMul}; end
        default:      bad = 1'b1;
      endcase

      case (r.addr_mode)
        AM_REG: begin
          mod_f = ModReg; rm = blo; rex_b = r.base_num[3];
        end
        AM_BASE: begin
          // SIB escape and RIP encodings cannot serve as a plain base here.
          if (blo == RmSib || blo == RmRip) bad = 1'b1;
          mod_f = ModInd; rm = blo; rex_b = r.base_num[3];
        end
        AM_BASE_D8, AM_BASE_D32: begin
          if (blo == RmSib) bad = 1'b1;
          mod_f    = (r.addr_mode == AM_BASE_D8) ? ModDisp8 : ModDisp32;
          disp_len = (r.addr_mode == AM_BASE_D8) ? 1 : 4;
          rm = blo; rex_b = r.base_num[3];
        end
        AM_SIB, AM_SIB_D8, AM_SIB_D32: begin
          if (r.addr_mode == AM_SIB && blo == RmRip) bad = 1'b1;
          case (r.addr_mode)
            AM_SIB:    begin mod_f = ModInd;    disp_len = 0; end
            AM_SIB_D8: begin mod_f = ModDisp8;  disp_len = 1; end
            default:   begin mod_f = ModDisp32; disp_len = 4; end
          endcase
          rm      = RmSib;
          has_sib = 1'b1;
          sib     = {r.scale_log, r.index_num[2:0], blo};
          rex_x   = r.index_num[3];
          rex_b   = r.base_num[3];
        end
        AM_RIP: begin
          mod_f = ModInd; rm = RmRip; disp_len = 4;
        end
        AM_ABS: begin
          mod_f = ModInd; rm = RmSib; has_sib = 1'b1; sib = SibAbs; disp_len = 4;
        end
        default: bad = 1'b1;
      endcase

      if (bad) begin
        expected_code.push_back('{8'h00, 1'b1, 1'b1});
        return;
      end

      enc.push_back(RexW | {5'b0, regf[3], rex_x, rex_b});
      enc.push_back(opcode);
      enc.push_back({mod_f, regf[2:0], rm});
      if (has_sib) enc.push_back(sib);
      for (int i = 0; i < int'(disp_len); i++) enc.push_back(r.displacement[8*i +: 8]);
      if (has_imm) begin
        for (int i = 0; i < 4; i++) enc.push_back(r.immediate[8*i +: 8]);
      end
    end

    foreach (enc[i]) expected_code.push_back('{enc[i], i == enc.size() - 1, 1'b0});
  endfunction

  function automatic request_t random_request();
    request_t r;
    if ($urandom_range(19) == 0) r.cmd = 4'($urandom_range(CmdBadHi, CmdBadLo));
    else r.cmd = 4'($urandom_range(CMD_JCC, CMD_ADD_R_RM));
    if ($urandom_range(19) == 0) r.addr_mode = 4'($urandom_range(AmBadHi, AmBadLo));
    else r.addr_mode = 4'($urandom_range(AM_ABS, AM_REG));
    r.reg_num      = 4'($urandom);
    r.base_num     = 4'($urandom);
    r.index_num    = 4'($urandom);
    r.scale_log    = 2'($urandom);
    r.displacement = $urandom;
    r.immediate    = $urandom;
    r.cond_code    = 4'($urandom);
    return r;
  endfunction

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] MISMATCH after %0d instructions: %s", $realtime, instrs_encoded, what);
  endtask

  // Offers one request and returns once it has been taken.
  task automatic offer_request(input request_t r);
    int unsigned gap;
    gap = steady_run ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= r.cmd;
    req_if.addr_mode    <= r.addr_mode;
    req_if.reg_num      <= r.reg_num;
    req_if.base_num     <= r.base_num;
    req_if.index_num    <= r.index_num;
    req_if.scale_log    <= r.scale_log;
    req_if.displacement <= r.displacement;
    req_if.immediate    <= r.immediate;
    req_if.cond_code    <= r.cond_code;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    instrs_sent++;
    if (r.cmd == CMD_JMP || r.cmd == CMD_JCC) jumps_sent++;
  endtask

  task automatic check_code_item();
    code_item_t want;
    if (expected_code.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h last %0b bad %0b",
                                rsp_if.code_byte, rsp_if.last_byte, rsp_if.bad_operand));
      return;
    end
    want = expected_code.pop_front();
    if (rsp_if.code_byte !== want.code)
      report_mismatch($sformatf("code_byte %02h, wanted %02h", rsp_if.code_byte, want.code));
    if (rsp_if.last_byte !== want.last)
      report_mismatch($sformatf("last_byte %b, wanted %b", rsp_if.last_byte, want.last));
    if (rsp_if.bad_operand !== want.bad)
      report_mismatch($sformatf("bad_operand %b, wanted %b", rsp_if.bad_operand, want.bad));
    if (want.bad) rejects_sent++;
    if (want.last) instrs_encoded++;
    bytes_checked++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d bytes outstanding", CycleLimit,
             expected_code.size());
    $display("x86_64_instruction_encoder regression: fail");
    $finish;
  end

  // Byte receiver: checks each item taken and decides the next ready.
  initial begin
    int unsigned stall_left;
    bit          held_off;
    stall_left = 0;
    held_off   = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_code_item();
      // One long hold-off lets the descriptor queue fill and stall requests.
      if (!held_off && bytes_checked == HoldAfterBytes) begin
        stall_left = LongHold;
        held_off   = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (steady_run || $urandom_range(99) < 65) begin
        rsp_if.ready <= 1'b1;
      end else begin
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
        stall_left--;
        rsp_if.ready <= 1'b0;
      end
    end
  end

  initial begin
    request_t req;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.cmd          <= '0;
    req_if.addr_mode    <= '0;
    req_if.reg_num      <= '0;
    req_if.base_num     <= '0;
    req_if.index_num    <= '0;
    req_if.scale_log    <= '0;
    req_if.displacement <= '0;
    req_if.immediate    <= '0;
    req_if.cond_code    <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req);
      if (directed_rows[i].exp_len == 0) begin
        encode_instruction(directed_rows[i].req);
      end else begin
        for (int b = 0; b < int'(directed_rows[i].exp_len); b++)
          expected_code.push_back('{directed_rows[i].exp_bytes[8*b +: 8],
                                    b == directed_rows[i].exp_len - 1,
                                    directed_rows[i].exp_bad});
      end
    end

    for (int n = 0; n < RandomItems; n++) begin
      steady_run = (n >= SteadyFirst && n < SteadyLast);
      req = random_request();
      offer_request(req);
      encode_instruction(req);
    end
    steady_run = 1'b0;
    req_if.valid <= 1'b0;

    while (expected_code.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d instructions (%0d jumps), %0d encoded, %0d rejected as bad operands.",
             instrs_sent, jumps_sent, instrs_encoded, rejects_sent);
    $display("Compared %0d code bytes; %0d mismatches reported.", bytes_checked, fail_count);
    if (fail_count == 0) begin
      $display("x86_64_instruction_encoder regression: pass");
    end else begin
      $display("x86_64_instruction_encoder regression: fail");
    end
    $finish;
  end

endmodule
